// ----- design/pcxrle_pkg.sv -----
// pcx run-length decoder: shared result codes, widths and header constants
// no dependencies
package pcxrle_pkg;

   localparam int unsigned POS_W    = 8;
   localparam int unsigned SIZE_W   = 17;
   localparam int unsigned PIXCNT_W = 33;
   localparam int unsigned RUN_W    = 6;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_PIXEL   = 2'd0;
   localparam kind_type KIND_SIZE    = 2'd1;
   localparam kind_type KIND_BAD_SIG = 2'd2;
   localparam kind_type KIND_BAD_EXT = 2'd3;

   localparam logic [7:0] SIG_MANUFACTURER = 8'd10;
   localparam logic [7:0] SIG_VERSION      = 8'd5;
   localparam logic [7:0] RUN_MARK_LIMIT   = 8'hBF;
   localparam logic [7:0] RUN_COUNT_MASK   = 8'h3F;

   localparam logic [POS_W-1:0] POS_MANUFACTURER = 8'd0;
   localparam logic [POS_W-1:0] POS_VERSION      = 8'd1;
   localparam logic [POS_W-1:0] POS_EXT_FIRST    = 8'd4;
   localparam logic [POS_W-1:0] POS_EXT_LAST     = 8'd11;

endpackage

// ----- design/pcx_rle_image_decoder.sv -----
// pcx run-length image decoder: header check, size report, rle pixel expansion
// a literal byte's pixel shows in the cycle after it is taken; byte 11 stalls the input
// through the size and check states before the size report; one byte per cycle while the
// output is free; a run value byte holds it for its run (up to 63) on the shared pixel counter
// reset is synchronous: header phase, position zero, nothing pending, output empty
module pcx_rle_image_decoder
   import pcxrle_pkg::*;
#(
   parameter int unsigned HEADER_BYTES = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_file_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output kind_type            rsp_kind,
   output logic [7:0]          rsp_pixel,
   output logic [SIZE_W-1:0]   rsp_width,
   output logic [SIZE_W-1:0]   rsp_height,
   output logic                rsp_run_end,
   output logic                rsp_image_end
);

   localparam logic [POS_W:0] HDR_END = HEADER_BYTES[POS_W:0];

   typedef enum logic [2:0] {
      ST_HEADER,
      ST_SIZE,
      ST_CHECK,
      ST_DATA,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [7:0]            ext_ff [8];
   logic [7:0]            ext_in [8];
   logic [SIZE_W:0]       wd_ff, wd_in;
   logic [SIZE_W:0]       ht_ff, ht_in;
   logic [PIXCNT_W-1:0]   left_ff, left_in;
   logic [RUN_W-1:0]      pend_ff, pend_in;
   logic                  armed_ff, armed_in;
   logic [RUN_W-1:0]      cnt_ff, cnt_in;
   logic [7:0]            runpix_ff, runpix_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              kind_ff, kind_in;
   logic [7:0]            pixel_ff, pixel_in;
   logic [SIZE_W-1:0]     width_ff, width_in;
   logic [SIZE_W-1:0]     height_ff, height_in;
   logic                  run_end_ff, run_end_in;
   logic                  image_end_ff, image_end_in;

   logic                  out_free;
   logic                  accept;
   logic                  take_state;
   logic [POS_W:0]        pos_next;
   logic [2:0]            ext_idx;
   logic [PIXCNT_W-1:0]   left_dec;
   logic                  left_one;
   logic [2*SIZE_W-1:0]   area;
   logic [RUN_W-1:0]      run_len;
   logic [7:0]            b;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign take_state = (state_ff == ST_HEADER) || (state_ff == ST_DATA) ||
                       (state_ff == ST_DONE);
   assign req_stall  = !(take_state && out_free);
   assign accept     = req_valid && !req_stall;
   assign b          = req_file_byte;
   assign pos_next   = {1'b0, pos_ff} + {{POS_W{1'b0}}, 1'b1};
   assign ext_idx    = 3'(pos_ff - POS_EXT_FIRST);

   // shared pixel counter decrement, used by literals and run pixels alike
   assign left_dec = left_ff - {{(PIXCNT_W-1){1'b0}}, 1'b1};
   assign left_one = (left_ff == {{(PIXCNT_W-1){1'b0}}, 1'b1});

   assign area = wd_ff[SIZE_W-1:0] * ht_ff[SIZE_W-1:0];

   // clip the run to the pixels still owed
   assign run_len = (left_ff < {{(PIXCNT_W-RUN_W){1'b0}}, pend_ff}) ?
                    left_ff[RUN_W-1:0] : pend_ff;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      ext_in       = ext_ff;
      wd_in        = wd_ff;
      ht_in        = ht_ff;
      left_in      = left_ff;
      pend_in      = pend_ff;
      armed_in     = armed_ff;
      cnt_in       = cnt_ff;
      runpix_in    = runpix_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      kind_in      = kind_ff;
      pixel_in     = pixel_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      run_end_in   = run_end_ff;
      image_end_in = image_end_ff;

      unique case (state_ff)
         ST_HEADER: begin
            if (accept) begin
               pos_in = pos_next[POS_W-1:0];
               if ((pos_ff == POS_MANUFACTURER && b != SIG_MANUFACTURER) ||
                   (pos_ff == POS_VERSION && b != SIG_VERSION)) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_BAD_SIG;
                  pixel_in     = '0;
                  width_in     = '0;
                  height_in    = '0;
                  run_end_in   = 1'b1;
                  image_end_in = 1'b0;
                  state_in     = ST_DONE;
               end else begin
                  if (pos_ff >= POS_EXT_FIRST && pos_ff <= POS_EXT_LAST) begin
                     ext_in[ext_idx] = b;
                  end
                  if (pos_ff == POS_EXT_LAST) begin
                     state_in = ST_SIZE;
                  end else if (pos_next >= HDR_END) begin
                     state_in = ST_DATA;
                     pend_in  = '0;
                     armed_in = 1'b0;
                  end
               end
            end
         end
         ST_SIZE: begin
            wd_in = {2'b00, ext_ff[5], ext_ff[4]} - {2'b00, ext_ff[1], ext_ff[0]} +
                    {{SIZE_W{1'b0}}, 1'b1};
            ht_in = {2'b00, ext_ff[7], ext_ff[6]} - {2'b00, ext_ff[3], ext_ff[2]} +
                    {{SIZE_W{1'b0}}, 1'b1};
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               pixel_in     = '0;
               run_end_in   = 1'b1;
               image_end_in = 1'b0;
               // negative or zero extent
               if (wd_ff[SIZE_W] || wd_ff == '0 || ht_ff[SIZE_W] || ht_ff == '0) begin
                  kind_in   = KIND_BAD_EXT;
                  width_in  = '0;
                  height_in = '0;
                  state_in  = ST_DONE;
               end else begin
                  kind_in   = KIND_SIZE;
                  width_in  = wd_ff[SIZE_W-1:0];
                  height_in = ht_ff[SIZE_W-1:0];
                  left_in   = area[PIXCNT_W-1:0];
                  if ({1'b0, pos_ff} >= HDR_END) begin
                     state_in = ST_DATA;
                     pend_in  = '0;
                     armed_in = 1'b0;
                  end else begin
                     state_in = ST_HEADER;
                  end
               end
            end
         end
         ST_DATA: begin
            if (accept) begin
               if (armed_ff) begin
                  armed_in = 1'b0;
                  pend_in  = '0;
                  if (run_len != '0) begin
                     cnt_in    = run_len;
                     runpix_in = b;
                     state_in  = ST_RUN;
                  end
               end else if (b > RUN_MARK_LIMIT) begin
                  pend_in  = RUN_W'(b & RUN_COUNT_MASK);
                  armed_in = 1'b1;
               end else begin
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_PIXEL;
                  pixel_in     = b;
                  width_in     = '0;
                  height_in    = '0;
                  run_end_in   = 1'b1;
                  image_end_in = left_one;
                  left_in      = left_dec;
                  if (left_one) begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_RUN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_PIXEL;
               pixel_in     = runpix_ff;
               width_in     = '0;
               height_in    = '0;
               run_end_in   = (cnt_ff == {{(RUN_W-1){1'b0}}, 1'b1});
               image_end_in = left_one;
               left_in      = left_dec;
               cnt_in       = cnt_ff - {{(RUN_W-1){1'b0}}, 1'b1};
               if (left_one) begin
                  state_in = ST_DONE;
               end else if (cnt_ff == {{(RUN_W-1){1'b0}}, 1'b1}) begin
                  state_in = ST_DATA;
               end
            end
         end
         ST_DONE: begin
            // bytes are taken and dropped until reset
         end
         default: begin
            state_in = ST_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_HEADER;
         pos_ff       <= '0;
         left_ff      <= '0;
         pend_ff      <= '0;
         armed_ff     <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            ext_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         left_ff      <= left_in;
         pend_ff      <= pend_in;
         armed_ff     <= armed_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         ext_ff       <= ext_in;
      end
      wd_ff        <= wd_in;
      ht_ff        <= ht_in;
      runpix_ff    <= runpix_in;
      kind_ff      <= kind_in;
      pixel_ff     <= pixel_in;
      width_ff     <= width_in;
      height_ff    <= height_in;
      run_end_ff   <= run_end_in;
      image_end_ff <= image_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_pixel     = pixel_ff;
   assign rsp_width     = width_ff;
   assign rsp_height    = height_ff;
   assign rsp_run_end   = run_end_ff;
   assign rsp_image_end = image_end_ff;

endmodule
